[design/sdspi_pkg.sv]
// Shared types, codes and helpers for the SD card SPI-mode responder.
// Used by sdspi_engine, sd_card_spi_responder and sdspi_checker; no dependencies.

package sdspi_pkg;

  // Default data block length in bytes
  localparam int SDSPI_BLOCK_BYTES = 512;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_SELECT   = 2'd0,
    REQ_DESELECT = 2'd1,
    REQ_BYTE     = 2'd2,
    REQ_READ     = 2'd3
  } sdspi_req_t;

  // CRC check report codes
  localparam logic [2:0] CRC_NONE     = 3'd0;
  localparam logic [2:0] CRC_MSB_GOOD = 3'd1;
  localparam logic [2:0] CRC_MSB_BAD  = 3'd2;
  localparam logic [2:0] CRC_LSB_GOOD = 3'd3;
  localparam logic [2:0] CRC_LSB_BAD  = 3'd4;

  // Initialisation stages; below STAGE_CMD0 the card is counting wake bytes
  localparam logic [3:0] STAGE_CMD0  = 4'd8;
  localparam logic [3:0] STAGE_CMD8  = 4'd9;
  localparam logic [3:0] STAGE_CMD55 = 4'd10;
  localparam logic [3:0] STAGE_CMD41 = 4'd11;
  localparam logic [3:0] STAGE_READY = 4'd12;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_READ_BLK   = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLK  = 6'd24;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_APP_PREFIX = 6'd55;

  // Command framing and tokens
  localparam logic [7:0]  CMD_FIRST_LO  = 8'h40;
  localparam logic [7:0]  CMD_FIRST_HI  = 8'h7F;
  localparam logic [2:0]  CMD_LAST_IDX  = 3'd5;
  localparam logic [15:0] IF_COND_ARG   = 16'h01AA;
  localparam logic [15:0] OP_COND_ARG   = 16'h4000;
  localparam logic [7:0]  DATA_TOKEN    = 8'hFE;
  localparam logic [7:0]  DATA_ACCEPTED = 8'h05;
  localparam logic [7:0]  IDLE_BYTE     = 8'hFF;
  localparam logic [7:0]  R1_IDLE       = 8'h01;
  localparam logic [7:0]  R1_READY      = 8'h00;

  // Reply buffer
  localparam int         REPLY_DEPTH = 5;
  localparam logic [2:0] REPLY_LAST  = 3'd4;
  localparam logic [2:0] REPLY_PAIR  = 3'd3;

  // Block write state, one-hot
  typedef enum logic [2:0] {
    WR_IDLE  = 3'b001,
    WR_TOKEN = 3'b010,
    WR_DATA  = 3'b100
  } sdspi_wr_t;

  // One result item
  typedef struct packed {
    logic [2:0]  crc_check;
    logic [7:0]  write_byte;
    logic        store_write;
    logic        store_read_take;
    logic [15:0] seek_block;
    logic        store_seek;
    logic [7:0]  read_data;
  } sdspi_result_t;

  // One CRC16-CCITT byte step, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                             input logic [7:0] data);
    logic [7:0]  x;
    logic [15:0] xw;
    x  = crc[15:8] ^ data;
    x  = x ^ (x >> 4);
    xw = {8'h00, x};
    return {crc[7:0], 8'h00} ^ (xw << 12) ^ (xw << 5) ^ xw;
  endfunction

endpackage

[design/sdspi_engine.sv]
// Card-side protocol engine: selection, wake count, command decode, block
// read and write sequencing. Depends on sdspi_pkg.

module sdspi_engine import sdspi_pkg::*; #(
  parameter int BLOCK_BYTES = SDSPI_BLOCK_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  sdspi_req_t    req,
  input  logic [7:0]    mosi_byte,
  input  logic [7:0]    store_byte,
  input  logic          store_present,
  output sdspi_result_t result
);

  localparam int RC_W = $clog2(BLOCK_BYTES);
  localparam int WP_W = $clog2(BLOCK_BYTES + 2);
  localparam logic [RC_W-1:0] READ_LAST  = RC_W'(BLOCK_BYTES - 1);
  localparam logic [WP_W-1:0] WP_BLOCK   = WP_W'(BLOCK_BYTES);

  logic                card_selected, card_selected_next;
  logic [3:0]          init_stage, init_stage_next;
  logic [2:0]          cmd_index, cmd_index_next;
  logic [7:0]          cmd_bytes [CMD_LAST_IDX];
  logic                cmd_we;
  logic                reply_busy, reply_busy_next;
  logic [2:0]          reply_index, reply_index_next;
  logic [7:0]          reply_bytes [REPLY_DEPTH];
  logic [7:0]          reply_bytes_next [REPLY_DEPTH];
  logic                read_busy, read_busy_next;
  logic [RC_W-1:0]     read_count, read_count_next;
  sdspi_wr_t           write_mode, write_mode_next;
  logic [WP_W-1:0]     write_phase, write_phase_next;
  logic [15:0]         crc_acc, crc_acc_next;
  logic [7:0]          resp_byte, resp_byte_next;

  logic [5:0]          cmd_code;
  logic [15:0]         arg_hi, arg_lo;
  logic [7:0]          rd_byte;
  logic [15:0]         crc_rd, crc_wr;

  assign cmd_code = cmd_bytes[0][5:0];
  assign arg_hi   = {cmd_bytes[1], cmd_bytes[2]};
  assign arg_lo   = {cmd_bytes[3], cmd_bytes[4]};
  assign rd_byte  = store_present ? store_byte : IDLE_BYTE;
  assign crc_rd   = crc16_step(crc_acc, rd_byte);
  assign crc_wr   = crc16_step(crc_acc, mosi_byte);

  // Work out the next state and the result for one event
  always_comb begin
    card_selected_next = card_selected;
    init_stage_next    = init_stage;
    cmd_index_next     = cmd_index;
    cmd_we             = 1'b0;
    reply_busy_next    = reply_busy;
    reply_index_next   = reply_index;
    reply_bytes_next   = reply_bytes;
    read_busy_next     = read_busy;
    read_count_next    = read_count;
    write_mode_next    = write_mode;
    write_phase_next   = write_phase;
    crc_acc_next       = crc_acc;
    resp_byte_next     = resp_byte;

    result                 = '0;
    result.read_data       = IDLE_BYTE;
    result.crc_check       = CRC_NONE;

    if (step_en) begin
      case (req)
        REQ_SELECT: begin
          card_selected_next = 1'b1;
        end
        REQ_DESELECT: begin
          card_selected_next = 1'b0;
        end
        REQ_READ: begin
          result.read_data = card_selected ? resp_byte : IDLE_BYTE;
        end
        REQ_BYTE: begin
          if (card_selected) begin
            resp_byte_next = IDLE_BYTE;
            if (init_stage < STAGE_CMD0) begin
              // count wake bytes
              init_stage_next = init_stage + 4'd1;
            end else if (reply_busy) begin
              // shift out the pending reply
              resp_byte_next   = reply_bytes[reply_index];
              reply_index_next = reply_index + 3'd1;
              if (reply_index == REPLY_LAST) begin
                reply_busy_next = 1'b0;
              end
            end else if (read_busy) begin
              // stream one block byte and fold it into the CRC
              resp_byte_next         = rd_byte;
              result.store_read_take = store_present;
              crc_acc_next           = crc_rd;
              read_count_next        = read_count + RC_W'(1);
              if (read_count == READ_LAST) begin
                reply_bytes_next[REPLY_PAIR] = crc_rd[15:8];
                reply_bytes_next[REPLY_LAST] = crc_rd[7:0];
                reply_busy_next  = 1'b1;
                reply_index_next = REPLY_PAIR;
                read_busy_next   = 1'b0;
                read_count_next  = '0;
              end
            end else if (write_mode == WR_TOKEN) begin
              // wait for the start token, skip idle fill
              if (mosi_byte == DATA_TOKEN) begin
                write_mode_next  = WR_DATA;
                write_phase_next = '0;
              end else if (mosi_byte != IDLE_BYTE) begin
                write_mode_next = WR_IDLE;
              end
            end else if (write_mode == WR_DATA) begin
              if (write_phase < WP_BLOCK) begin
                // pass a data byte to the store
                result.store_write = store_present;
                result.write_byte  = store_present ? mosi_byte : 8'h00;
                crc_acc_next       = crc_wr;
                write_phase_next   = write_phase + WP_W'(1);
              end else if (write_phase == WP_BLOCK) begin
                result.crc_check = (mosi_byte == crc_acc[15:8]) ? CRC_MSB_GOOD
                                                                : CRC_MSB_BAD;
                write_phase_next = write_phase + WP_W'(1);
              end else begin
                result.crc_check = (mosi_byte == crc_acc[7:0]) ? CRC_LSB_GOOD
                                                               : CRC_LSB_BAD;
                reply_bytes_next[REPLY_LAST] = DATA_ACCEPTED;
                reply_busy_next  = 1'b1;
                reply_index_next = REPLY_LAST;
                write_mode_next  = WR_IDLE;
                write_phase_next = '0;
              end
            end else if (cmd_index == 3'd0 &&
                         !(mosi_byte inside {[CMD_FIRST_LO:CMD_FIRST_HI]})) begin
              // drop bytes that cannot open a command
            end else if (cmd_index != CMD_LAST_IDX) begin
              // collect a command byte
              cmd_we         = 1'b1;
              cmd_index_next = cmd_index + 3'd1;
            end else begin
              // last command byte: decode
              cmd_index_next = '0;
              if (init_stage == STAGE_CMD0) begin
                if (cmd_code == CMD_GO_IDLE) begin
                  init_stage_next              = STAGE_CMD8;
                  reply_bytes_next[REPLY_LAST] = R1_IDLE;
                  reply_busy_next              = 1'b1;
                  reply_index_next             = REPLY_LAST;
                end
              end else if (init_stage == STAGE_CMD8) begin
                if (cmd_code == CMD_SEND_IF && arg_lo == IF_COND_ARG) begin
                  init_stage_next     = STAGE_CMD55;
                  reply_bytes_next[0] = R1_IDLE;
                  reply_bytes_next[1] = 8'h00;
                  reply_bytes_next[2] = 8'h00;
                  reply_bytes_next[3] = IF_COND_ARG[15:8];
                  reply_bytes_next[4] = IF_COND_ARG[7:0];
                  reply_busy_next     = 1'b1;
                  reply_index_next    = 3'd0;
                end else begin
                  init_stage_next = STAGE_CMD0;
                end
              end else if (init_stage == STAGE_CMD55) begin
                if (cmd_code == CMD_APP_PREFIX) begin
                  init_stage_next              = STAGE_CMD41;
                  reply_bytes_next[REPLY_LAST] = R1_IDLE;
                  reply_busy_next              = 1'b1;
                  reply_index_next             = REPLY_LAST;
                end else begin
                  init_stage_next = STAGE_CMD0;
                end
              end else if (init_stage == STAGE_CMD41) begin
                if (cmd_code == CMD_APP_OP && arg_hi == OP_COND_ARG) begin
                  init_stage_next              = STAGE_READY;
                  reply_bytes_next[REPLY_LAST] = R1_READY;
                  reply_busy_next              = 1'b1;
                  reply_index_next             = REPLY_LAST;
                end else begin
                  init_stage_next = STAGE_CMD0;
                end
              end else if (cmd_code == CMD_READ_BLK) begin
                result.store_seek            = store_present;
                result.seek_block            = store_present ? arg_lo : 16'h0000;
                crc_acc_next                 = '0;
                reply_bytes_next[REPLY_PAIR] = R1_READY;
                reply_bytes_next[REPLY_LAST] = DATA_TOKEN;
                reply_busy_next              = 1'b1;
                reply_index_next             = REPLY_PAIR;
                read_busy_next               = 1'b1;
                read_count_next              = '0;
              end else if (cmd_code == CMD_WRITE_BLK) begin
                result.store_seek            = store_present;
                result.seek_block            = store_present ? arg_lo : 16'h0000;
                crc_acc_next                 = '0;
                reply_bytes_next[REPLY_LAST] = R1_READY;
                reply_busy_next              = 1'b1;
                reply_index_next             = REPLY_LAST;
                write_mode_next              = WR_TOKEN;
                write_phase_next             = '0;
              end else begin
                reply_bytes_next[REPLY_LAST] = R1_READY;
                reply_busy_next              = 1'b1;
                reply_index_next             = REPLY_LAST;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      card_selected <= 1'b0;
      init_stage    <= '0;
      cmd_index     <= '0;
      reply_busy    <= 1'b0;
      reply_index   <= '0;
      read_busy     <= 1'b0;
      read_count    <= '0;
      write_mode    <= WR_IDLE;
      write_phase   <= '0;
      crc_acc       <= '0;
      resp_byte     <= IDLE_BYTE;
    end else begin
      card_selected <= card_selected_next;
      init_stage    <= init_stage_next;
      cmd_index     <= cmd_index_next;
      reply_busy    <= reply_busy_next;
      reply_index   <= reply_index_next;
      read_busy     <= read_busy_next;
      read_count    <= read_count_next;
      write_mode    <= write_mode_next;
      write_phase   <= write_phase_next;
      crc_acc       <= crc_acc_next;
      resp_byte     <= resp_byte_next;
    end
  end

  // Command and reply byte buffers, no reset
  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_bytes[cmd_index] <= mosi_byte;
    end
    reply_bytes <= reply_bytes_next;
  end

endmodule

[design/sd_card_spi_responder.sv]
// Top level of the SD card SPI-mode responder: stream handshake, result
// register and configuration register. Depends on sdspi_pkg and sdspi_engine.
//
// Usage:
//   Input beats arrive on s_axis_*: tuser carries the event kind (select,
//   deselect, SPI byte from host, read of the MISO byte), tdata carries the
//   host byte and the next backing-store byte. Every input beat yields exactly
//   one output beat on m_axis_* with the MISO byte, store seek/read/write
//   strobes, write data and the CRC check code.
//   Each accepted beat is registered and presented on m_axis_* in the cycle
//   after it is accepted. Throughput is one beat per cycle while the
//   receiver does not stall; the whole event is decoded by the engine
//   between the input port and the result register.
//   When the receiver stalls, the result register holds its beat and
//   s_axis_tready drops until the beat is taken; a beat can be accepted in
//   the same cycle the waiting one leaves.
//   cfg_we/cfg_wdata write the store-present flag; write it only while idle.
//   Reset (rst, synchronous) deselects the card, restarts the wake count and
//   initialisation, clears the store-present flag and empties the result
//   register.

module sd_card_spi_responder import sdspi_pkg::*; #(
  parameter int BLOCK_BYTES = SDSPI_BLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mosi_byte[7:0], store_byte[15:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_data[7:0], store_seek[8],
                                      // seek_block[24:9], store_read_take[25],
                                      // store_write[26], write_byte[34:27],
                                      // crc_check[37:35], zero[39:38]
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic          store_present;
  logic          in_beat;
  sdspi_result_t result;

  // Accept while the result register is free or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Hold the store-present flag
  always_ff @(posedge clk) begin
    if (rst) begin
      store_present <= 1'b0;
    end else if (cfg_we) begin
      store_present <= cfg_wdata;
    end
  end

  sdspi_engine #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .step_en       (in_beat),
    .req           (sdspi_req_t'(s_axis_tuser)),
    .mosi_byte     (s_axis_tdata[7:0]),
    .store_byte    (s_axis_tdata[15:8]),
    .store_present (store_present),
    .result        (result)
  );

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= {2'b00, result};
    end
  end

endmodule

[design/sdspi_checker.sv]
// Port-level checks for sd_card_spi_responder, attached by bind.
// Depends on sdspi_pkg.

module sdspi_checker import sdspi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Every non-read event answers with the idle byte on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_READ
    |=> m_axis_tvalid && m_axis_tdata[7:0] == IDLE_BYTE)
    else $error("non-read event gave a response byte");

  // Seek and write data are zero unless their strobes are raised
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[8] || m_axis_tdata[24:9] == 16'h0000) &&
                      (m_axis_tdata[26] || m_axis_tdata[34:27] == 8'h00))
    else $error("seek block or write byte without strobe");

  // Store strobes and CRC report are mutually exclusive and codes are valid
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $countones({m_axis_tdata[8], m_axis_tdata[25], m_axis_tdata[26],
                                  m_axis_tdata[37:35] != CRC_NONE}) <= 1 &&
                      m_axis_tdata[37:35] <= CRC_LSB_BAD &&
                      m_axis_tdata[39:38] == 2'b00)
    else $error("conflicting store strobes or bad crc code");

endmodule

bind sd_card_spi_responder sdspi_checker u_sdspi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/sd_card_spi_responder_test.sv]
// Self-checking bench for sd_card_spi_responder: drives select, deselect, SPI byte and
// MISO read beats, predicts every result beat and compares field by field.
// Depends on sdspi_pkg and the responder RTL only.
`timescale 1ns / 1ps

module sd_card_spi_responder_test;
  import sdspi_pkg::*;

  localparam int          BLK        = SDSPI_BLOCK_BYTES;
  localparam int          CMD_BYTES  = 6;
  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // Directed stimulus row; read_data is compared directly when pinned is set
  typedef struct packed {
    sdspi_req_t req;
    logic [7:0] mosi;
    logic [7:0] sb;
    logic       pinned;
    logic [7:0] read_data;
  } stim_row_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{REQ_READ,     8'h00, 8'h00, 1'b1, IDLE_BYTE},  // read while deselected after reset
    '{REQ_BYTE,     8'h00, 8'h00, 1'b1, IDLE_BYTE},  // byte while deselected is ignored
    '{REQ_BYTE,     8'hFF, 8'hFF, 1'b1, IDLE_BYTE},
    '{REQ_SELECT,   8'h00, 8'hFF, 1'b1, IDLE_BYTE},
    '{REQ_READ,     8'hFF, 8'h00, 1'b1, IDLE_BYTE},  // MISO idles high after reset
    '{REQ_BYTE,     8'h40, 8'h00, 1'b1, IDLE_BYTE},  // eight wake bytes
    '{REQ_BYTE,     8'h00, 8'hFF, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'hFF, 8'h00, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'h7F, 8'hAA, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'h80, 8'h55, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'h3F, 8'h01, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'hAA, 8'h80, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'h55, 8'h7F, 1'b1, IDLE_BYTE},
    '{REQ_READ,     8'h00, 8'h00, 1'b1, IDLE_BYTE},
    '{REQ_BYTE,     8'h3F, 8'h12, 1'b0, IDLE_BYTE},  // below the command range: dropped
    '{REQ_BYTE,     8'h80, 8'h34, 1'b0, IDLE_BYTE},  // above the command range: dropped
    '{REQ_BYTE,     8'h51, 8'h56, 1'b0, IDLE_BYTE},  // block read before CMD0
    '{REQ_BYTE,     8'h00, 8'h78, 1'b0, IDLE_BYTE},
    '{REQ_BYTE,     8'h00, 8'h9A, 1'b0, IDLE_BYTE},
    '{REQ_BYTE,     8'h00, 8'hBC, 1'b0, IDLE_BYTE},
    '{REQ_BYTE,     8'h00, 8'hDE, 1'b0, IDLE_BYTE},
    '{REQ_BYTE,     8'hFF, 8'hF0, 1'b0, IDLE_BYTE},  // ignored, no reply
    '{REQ_READ,     8'h00, 8'h00, 1'b1, IDLE_BYTE},
    '{REQ_DESELECT, 8'h00, 8'h00, 1'b1, IDLE_BYTE},
    '{REQ_READ,     8'hFF, 8'hFF, 1'b1, IDLE_BYTE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;        // mosi_byte[7:0], store_byte[15:8]
  logic [1:0]  s_axis_tuser = REQ_SELECT; // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;             // read_data, store_seek, seek_block, take,
                                         // store_write, write_byte, crc_check, pad
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Side information travelling with each beat
  logic        beat_pinned = 1'b0;
  logic [7:0]  beat_pin_rd = IDLE_BYTE;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int blocks_read = 0;
  int blocks_written = 0;
  int crc_faults = 0;

  sdspi_result_t expected_q [$];

  // Card state as predicted by the bench
  logic        store_on;
  logic        card_on;
  logic [3:0]  init_lvl;
  int          cmd_pos;
  logic [7:0]  cmd_buf [CMD_BYTES];
  logic        reply_pend;
  int          reply_pos;
  logic [7:0]  reply_buf [REPLY_DEPTH];
  logic        streaming;
  int          stream_cnt;
  sdspi_wr_t   wr_mode;
  int          wr_cnt;
  logic [15:0] crc_run;
  logic [7:0]  miso_byte;
  bit          bad_tried [16];

  sd_card_spi_responder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // CRC16-CCITT, bit-serial, MSB first
  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int b = 7; b >= 0; b--) begin
      fb  = crc[15] ^ data[b];
      crc = {crc[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void model_reset();
    store_on   = 1'b0;
    card_on    = 1'b0;
    init_lvl   = '0;
    cmd_pos    = 0;
    reply_pend = 1'b0;
    reply_pos  = 0;
    streaming  = 1'b0;
    stream_cnt = 0;
    wr_mode    = WR_IDLE;
    wr_cnt     = 0;
    crc_run    = '0;
    miso_byte  = IDLE_BYTE;
    foreach (cmd_buf[i]) cmd_buf[i] = '0;
    foreach (reply_buf[i]) reply_buf[i] = '0;
  endfunction

  function automatic void begin_reply(int first);
    reply_pend = 1'b1;
    reply_pos  = first;
  endfunction

  // Advance the card by one host byte
  function automatic sdspi_result_t clock_byte(logic [7:0] val, logic [7:0] sb);
    sdspi_result_t r;
    logic [5:0]    cmd;
    logic [15:0]   arg_hi;
    logic [15:0]   arg_lo;
    r = '0;
    r.read_data = IDLE_BYTE;
    if (!card_on) return r;
    miso_byte = IDLE_BYTE;
    if (init_lvl < STAGE_CMD0) begin
      init_lvl++;
      return r;
    end
    // pending reply goes out first
    if (reply_pend) begin
      miso_byte = reply_buf[reply_pos];
      reply_pos++;
      if (reply_pos >= REPLY_DEPTH) reply_pend = 1'b0;
      return r;
    end
    if (streaming) begin
      if (store_on) begin
        miso_byte = sb;
        r.store_read_take = 1'b1;
      end
      crc_run = crc_add(crc_run, miso_byte);
      stream_cnt++;
      if (stream_cnt >= BLK) begin
        reply_buf[REPLY_PAIR] = crc_run[15:8];
        reply_buf[REPLY_LAST] = crc_run[7:0];
        begin_reply(REPLY_PAIR);
        streaming  = 1'b0;
        stream_cnt = 0;
        blocks_read++;
      end
      return r;
    end
    // token wait: skip idle bytes, cancel on anything but the token
    if (wr_mode == WR_TOKEN) begin
      if (val == IDLE_BYTE) return r;
      if (val == DATA_TOKEN) begin
        wr_mode = WR_DATA;
        wr_cnt  = 0;
      end else begin
        wr_mode = WR_IDLE;
      end
      return r;
    end
    if (wr_mode == WR_DATA) begin
      if (wr_cnt < BLK) begin
        if (store_on) begin
          r.store_write = 1'b1;
          r.write_byte  = val;
        end
        crc_run = crc_add(crc_run, val);
        wr_cnt++;
      end else if (wr_cnt == BLK) begin
        r.crc_check = (val == crc_run[15:8]) ? CRC_MSB_GOOD : CRC_MSB_BAD;
        wr_cnt++;
      end else begin
        r.crc_check = (val == crc_run[7:0]) ? CRC_LSB_GOOD : CRC_LSB_BAD;
        reply_buf[REPLY_LAST] = DATA_ACCEPTED;
        begin_reply(REPLY_LAST);
        wr_mode = WR_IDLE;
        wr_cnt  = 0;
        blocks_written++;
      end
      return r;
    end
    // collect a command frame
    if (cmd_pos == 0 && (val > CMD_FIRST_HI || val < CMD_FIRST_LO)) return r;
    cmd_buf[cmd_pos] = val;
    cmd_pos++;
    if (cmd_pos < CMD_BYTES) return r;
    cmd_pos = 0;
    cmd    = cmd_buf[0][5:0];
    arg_hi = {cmd_buf[1], cmd_buf[2]};
    arg_lo = {cmd_buf[3], cmd_buf[4]};

    if (init_lvl == STAGE_CMD0) begin
      if (cmd == CMD_GO_IDLE) begin
        init_lvl = STAGE_CMD8;
        reply_buf[REPLY_LAST] = R1_IDLE;
        begin_reply(REPLY_LAST);
      end
      return r;
    end
    if (init_lvl == STAGE_CMD8) begin
      if (cmd == CMD_SEND_IF && arg_lo == IF_COND_ARG) begin
        init_lvl = STAGE_CMD55;
        reply_buf[0] = R1_IDLE;
        reply_buf[1] = 8'h00;
        reply_buf[2] = 8'h00;
        reply_buf[3] = IF_COND_ARG[15:8];
        reply_buf[4] = IF_COND_ARG[7:0];
        begin_reply(0);
      end else begin
        init_lvl = STAGE_CMD0;
      end
      return r;
    end
    if (init_lvl == STAGE_CMD55) begin
      if (cmd == CMD_APP_PREFIX) begin
        init_lvl = STAGE_CMD41;
        reply_buf[REPLY_LAST] = R1_IDLE;
        begin_reply(REPLY_LAST);
      end else begin
        init_lvl = STAGE_CMD0;
      end
      return r;
    end
    if (init_lvl == STAGE_CMD41) begin
      if (cmd == CMD_APP_OP && arg_hi == OP_COND_ARG) begin
        init_lvl = STAGE_READY;
        reply_buf[REPLY_LAST] = R1_READY;
        begin_reply(REPLY_LAST);
      end else begin
        init_lvl = STAGE_CMD0;
      end
      return r;
    end
    if (cmd == CMD_READ_BLK || cmd == CMD_WRITE_BLK) begin
      if (store_on) begin
        r.store_seek = 1'b1;
        r.seek_block = arg_lo;
      end
      crc_run = '0;
      if (cmd == CMD_READ_BLK) begin
        reply_buf[REPLY_PAIR] = R1_READY;
        reply_buf[REPLY_LAST] = DATA_TOKEN;
        begin_reply(REPLY_PAIR);
        streaming  = 1'b1;
        stream_cnt = 0;
      end else begin
        reply_buf[REPLY_LAST] = R1_READY;
        begin_reply(REPLY_LAST);
        wr_mode = WR_TOKEN;
        wr_cnt  = 0;
      end
      return r;
    end
    reply_buf[REPLY_LAST] = R1_READY;
    begin_reply(REPLY_LAST);
    return r;
  endfunction

  function automatic sdspi_result_t predict_event(sdspi_req_t req, logic [7:0] mosi,
                                                  logic [7:0] sb);
    sdspi_result_t r;
    r = '0;
    r.read_data = IDLE_BYTE;
    case (req)
      REQ_SELECT:   card_on = 1'b1;
      REQ_DESELECT: card_on = 1'b0;
      REQ_BYTE:     r = clock_byte(mosi, sb);
      default:      r.read_data = card_on ? miso_byte : IDLE_BYTE;
    endcase
    return r;
  endfunction

  task automatic flag_field(string name, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
  endtask

  task automatic check_result(sdspi_result_t due, logic [39:0] raw);
    sdspi_result_t seen;
    seen = sdspi_result_t'(raw[37:0]);
    if (seen.read_data !== due.read_data)
      flag_field("read_data", 16'(due.read_data), 16'(seen.read_data));
    if (seen.store_seek !== due.store_seek)
      flag_field("store_seek", 16'(due.store_seek), 16'(seen.store_seek));
    if (seen.seek_block !== due.seek_block)
      flag_field("seek_block", due.seek_block, seen.seek_block);
    if (seen.store_read_take !== due.store_read_take)
      flag_field("store_read_take", 16'(due.store_read_take), 16'(seen.store_read_take));
    if (seen.store_write !== due.store_write)
      flag_field("store_write", 16'(due.store_write), 16'(seen.store_write));
    if (seen.write_byte !== due.write_byte)
      flag_field("write_byte", 16'(due.write_byte), 16'(seen.write_byte));
    if (seen.crc_check !== due.crc_check)
      flag_field("crc_check", 16'(due.crc_check), 16'(seen.crc_check));
    if (raw[39:38] !== 2'b00)
      flag_field("padding", 16'h0000, 16'(raw[39:38]));
    results_checked++;
  endtask

  // Check leaving beats, predict entering beats, track register writes
  always @(posedge clk) begin : scoreboard
    sdspi_result_t due;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata);
        end else begin
          check_result(expected_q.pop_front(), m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due = predict_event(sdspi_req_t'(s_axis_tuser), s_axis_tdata[7:0],
                            s_axis_tdata[15:8]);
        if (due.crc_check == CRC_MSB_BAD || due.crc_check == CRC_LSB_BAD) crc_faults++;
        if (beat_pinned) begin
          due = '0;
          due.read_data = beat_pin_rd;
        end
        expected_q.push_back(due);
      end
      if (cfg_we) store_on = cfg_wdata;
    end
  end

  // Present one beat at the falling edge and hold it until taken
  task automatic send_event(sdspi_req_t req, logic [7:0] mosi, logic [7:0] sb,
                            logic pin, logic [7:0] pin_rd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {sb, mosi};
    beat_pinned   <= pin;
    beat_pin_rd   <= pin_rd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic sample_miso();
    send_event(REQ_READ, 8'($urandom), 8'($urandom), 1'b0, IDLE_BYTE);
  endtask

  // Clock one host byte, then read MISO back with the given chance
  task automatic host_byte(logic [7:0] val, int peek_pct);
    send_event(REQ_BYTE, val, 8'($urandom), 1'b0, IDLE_BYTE);
    if ($urandom_range(99) < peek_pct) sample_miso();
  endtask

  task automatic send_cmd(logic [5:0] idx, logic [31:0] arg);
    host_byte({2'b01, idx}, 15);
    for (int i = 3; i >= 0; i--) host_byte(arg[8*i +: 8], 15);
    host_byte(8'($urandom) | 8'h01, 15);
  endtask

  task automatic finish_reply();
    while (reply_pend)
      host_byte(($urandom_range(3) == 0) ? 8'($urandom) : IDLE_BYTE, 90);
    sample_miso();
  endtask

  // Bring the card to a quiet point: selected, awake, no frame or transfer open
  task automatic settle();
    if (!card_on) send_event(REQ_SELECT, 8'($urandom), 8'($urandom), 1'b0, IDLE_BYTE);
    while (init_lvl < STAGE_CMD0 || cmd_pos != 0 || reply_pend || streaming ||
           wr_mode != WR_IDLE)
      host_byte((wr_mode == WR_TOKEN) ? 8'h00 : IDLE_BYTE, 25);
  endtask

  // Next command of the start-up chain; spoil the first try at each stage and now and then a later one
  task automatic init_step();
    logic [5:0]  idx;
    logic [31:0] arg;
    arg = $urandom;
    if (init_lvl == STAGE_CMD0) begin
      idx = CMD_GO_IDLE;
    end else if (init_lvl == STAGE_CMD8) begin
      idx = CMD_SEND_IF;
      arg[15:0] = IF_COND_ARG;
    end else if (init_lvl == STAGE_CMD55) begin
      idx = CMD_APP_PREFIX;
    end else begin
      idx = CMD_APP_OP;
      arg[31:16] = OP_COND_ARG;
    end
    if (!bad_tried[init_lvl] || $urandom_range(99) < 10) begin
      bad_tried[init_lvl] = 1'b1;
      if ($urandom_range(1) == 1)
        idx = 6'($urandom);
      else if (init_lvl == STAGE_CMD8)
        arg[15:0] ^= 16'(1 << $urandom_range(15));
      else if (init_lvl == STAGE_CMD41)
        arg[31:16] ^= 16'(1 << $urandom_range(15));
      else
        idx ^= 6'(1 << $urandom_range(5));
    end
    send_cmd(idx, arg);
    finish_reply();
  endtask

  function automatic logic [31:0] block_arg();
    logic [31:0] arg;
    arg = $urandom;
    case ($urandom_range(3))
      0: arg[15:0] = 16'h0000;
      1: arg[15:0] = 16'hFFFF;
      default: ;
    endcase
    return arg;
  endfunction

  task automatic block_read();
    send_cmd(CMD_READ_BLK, block_arg());
    while (reply_pend || streaming)
      host_byte(8'($urandom), streaming ? 12 : 90);
    sample_miso();
  endtask

  task automatic block_write();
    logic [15:0] crc;
    logic [7:0]  val;
    send_cmd(CMD_WRITE_BLK, block_arg());
    while (reply_pend) host_byte(IDLE_BYTE, 90);
    if (wr_mode != WR_TOKEN) return;
    repeat ($urandom_range(3)) host_byte(IDLE_BYTE, 30);
    // now and then break off with a wrong token
    if ($urandom_range(99) < 15) begin
      do val = 8'($urandom); while (val == IDLE_BYTE || val == DATA_TOKEN);
      host_byte(val, 50);
      return;
    end
    host_byte(DATA_TOKEN, 20);
    crc = '0;
    repeat (BLK) begin
      val = 8'($urandom);
      crc = crc_add(crc, val);
      host_byte(val, 5);
    end
    host_byte(crc[15:8] ^ (($urandom_range(99) < 25) ? 8'(1 << $urandom_range(7)) : 8'h00), 20);
    host_byte(crc[7:0] ^ (($urandom_range(99) < 25) ? 8'(1 << $urandom_range(7)) : 8'h00), 20);
    finish_reply();
  endtask

  task automatic plain_command();
    logic [5:0] idx;
    do idx = 6'($urandom); while (idx == CMD_READ_BLK || idx == CMD_WRITE_BLK);
    send_cmd(idx, $urandom);
    finish_reply();
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 6))
      send_event(sdspi_req_t'(2'($urandom)), 8'($urandom), 8'($urandom), 1'b0, IDLE_BYTE);
  endtask

  // Mix of start-up, commands, noise and the block transfers asked for
  task automatic run_phase(int span, int n_rd, int n_wr);
    int first;
    int pick;
    first = beats_sent;
    while (n_rd + n_wr > 0 || beats_sent - first < span) begin
      settle();
      if (init_lvl != STAGE_READY) begin
        init_step();
      end else begin
        pick = $urandom_range(99);
        if (n_rd + n_wr > 0 && pick < 20) begin
          if (n_rd > 0 && (n_wr == 0 || $urandom_range(1) == 1)) begin
            block_read();
            n_rd--;
          end else begin
            block_write();
            n_wr--;
          end
        end else if (pick < 45) begin
          noise();
        end else begin
          plain_command();
        end
      end
    end
  endtask

  // Drop valid and wait for every expected beat to arrive
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_store(logic val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    model_reset();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows, store absent from reset
    send_idle_pct = 19;
    recv_idle_pct = 70;
    for (int i = 0; i < N_DIRECTED; i++)
      send_event(DIRECTED[i].req, DIRECTED[i].mosi, DIRECTED[i].sb,
                 DIRECTED[i].pinned, DIRECTED[i].read_data);
    drain_results();

    write_store(1'b1);
    run_phase(300, 1, 1);
    drain_results();

    send_idle_pct = 70;
    recv_idle_pct = 19;
    write_store(1'b0);
    run_phase(300, 1, 0);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_store(1'b1);
    run_phase(150, 0, 0);
    drain_results();
    repeat (4) @(negedge clk);

    $display("Covered %0d input beats and %0d checked results: start-up, commands, noise,",
             beats_sent, results_checked);
    $display("%0d block reads, %0d block writes, %0d bad CRC bytes, store attached and absent.",
             blocks_read, blocks_written, crc_faults);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("sd_card_spi_responder verification clean");
    end else begin
      $display("sd_card_spi_responder verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("sd_card_spi_responder verification failed");
    $finish;
  end

endmodule
